@@ hw/rtl/arp_pkg.sv @@
// Shared types and constants for the AT response parser.
// Character class word, status codes, counter caps. No dependencies.
package arp_pkg;

    // Response status codes
    localparam logic [1:0] STATUS_NOT_READY = 2'd0;
    localparam logic [1:0] STATUS_OK        = 2'd1;
    localparam logic [1:0] STATUS_ERR       = 2'd2;

    // Characters of interest
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_K     = 8'h4B;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] PRINT_LO = 8'd32;
    localparam logic [7:0] PRINT_HI = 8'd126;

    // Counter saturation points
    localparam int MAX_LINES    = 256;
    localparam int MAX_LINE_LEN = 256;
    localparam int LINE_CAP_INT = (MAX_LINES - 1) < 255 ? (MAX_LINES - 1) : 255;
    localparam int COL_CAP_INT  = (MAX_LINE_LEN - 1) < 255 ? (MAX_LINE_LEN - 1) : 255;
    localparam logic [7:0] LINE_CAP = 8'(LINE_CAP_INT);
    localparam logic [7:0] COL_CAP  = 8'(COL_CAP_INT);

    // Decoupling queue between classifier and engine
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One classified byte: flags for every class the recognizer tests
    typedef struct packed {
        logic is_cr;
        logic is_lf;
        logic is_o;
        logic is_k;
        logic is_e;
        logic is_r;
        logic is_plus;
        logic is_print;
    } arp_class_t;

    // Queue handshake towards the engine
    typedef struct packed {
        logic valid;
        logic pop;
    } arp_qctl_t;

endpackage

@@ hw/rtl/arp_classifier.sv @@
// Front end: decodes a received byte into its character class word.
// Depends on arp_pkg.
module arp_classifier (
    input  logic [7:0]          rx_byte,
    output arp_pkg::arp_class_t cls
);

    always_comb
    begin
        cls.is_cr    = (rx_byte == arp_pkg::CH_CR);
        cls.is_lf    = (rx_byte == arp_pkg::CH_LF);
        cls.is_o     = (rx_byte == arp_pkg::CH_O);
        cls.is_k     = (rx_byte == arp_pkg::CH_K);
        cls.is_e     = (rx_byte == arp_pkg::CH_E);
        cls.is_r     = (rx_byte == arp_pkg::CH_R);
        cls.is_plus  = (rx_byte == arp_pkg::CH_PLUS);
        cls.is_print = (rx_byte >= arp_pkg::PRINT_LO) && (rx_byte <= arp_pkg::PRINT_HI);
    end

endmodule

@@ hw/rtl/arp_queue.sv @@
// Short FIFO of class words between the classifier and the engine.
// Depends on arp_pkg.
module arp_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  arp_pkg::arp_class_t push_data,
    output logic                not_full,
    input  logic                pop,
    output logic                not_empty,
    output arp_pkg::arp_class_t pop_data
);

    arp_pkg::arp_class_t                mem_reg [arp_pkg::QUEUE_DEPTH];
    logic [arp_pkg::QPTR_W-1:0]         wr_ptr_reg, wr_ptr_next;
    logic [arp_pkg::QPTR_W-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [arp_pkg::QCNT_W-1:0]         count_reg, count_next;

    localparam logic [arp_pkg::QCNT_W-1:0] DEPTH_C = arp_pkg::QCNT_W'(arp_pkg::QUEUE_DEPTH);
    localparam logic [arp_pkg::QPTR_W-1:0] LAST_C  =
        arp_pkg::QPTR_W'(arp_pkg::QUEUE_DEPTH - 1);

    assign not_full  = (count_reg != DEPTH_C);
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_C) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_C) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ hw/rtl/arp_engine.sv @@
// Back end: response recognizer, line/column counters and output register.
// Depends on arp_pkg.
module arp_engine (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  arp_pkg::arp_class_t cls,
    output arp_pkg::arp_qctl_t  qctl,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          status,
    output logic [7:0]          line_index,
    output logic [7:0]          column
);

    localparam logic [4:0] S_WAIT_CR  = 5'd0;
    localparam logic [4:0] S_LF0      = 5'd1;
    localparam logic [4:0] S_REPLY0   = 5'd2;
    localparam logic [4:0] S_OK_K     = 5'd3;
    localparam logic [4:0] S_END_CR   = 5'd4;
    localparam logic [4:0] S_END_LF   = 5'd5;
    localparam logic [4:0] S_DONE     = 5'd6;
    localparam logic [4:0] S_ERR_R1   = 5'd7;
    localparam logic [4:0] S_ERR_R2   = 5'd8;
    localparam logic [4:0] S_ERR_O    = 5'd9;
    localparam logic [4:0] S_ERR_R3   = 5'd10;
    localparam logic [4:0] S_ERR_CR   = 5'd11;
    localparam logic [4:0] S_PLUS_TXT = 5'd12;
    localparam logic [4:0] S_PLUS_LF  = 5'd13;
    localparam logic [4:0] S_PLUS_NXT = 5'd14;
    localparam logic [4:0] S_TAIL_LF  = 5'd15;
    localparam logic [4:0] S_REPLY1   = 5'd16;

    logic [4:0] state_reg, state_next;
    logic [7:0] line_reg, line_next;
    logic [7:0] col_reg, col_next;
    logic [1:0] status_reg, status_next;
    logic       out_valid_reg;
    logic       pop;

    assign pop        = q_valid && (!out_valid_reg || out_ready);
    assign qctl.valid = q_valid;
    assign qctl.pop   = pop;

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign line_index = line_reg;
    assign column     = col_reg;

    always_comb
    begin
        state_next  = state_reg;
        line_next   = line_reg;
        col_next    = col_reg;
        status_next = arp_pkg::STATUS_ERR;
        case (state_reg)
            S_WAIT_CR:
            begin
                status_next = arp_pkg::STATUS_NOT_READY;
                if (cls.is_cr) state_next = S_LF0;
            end
            S_LF0:
            begin
                if (cls.is_lf)
                begin
                    state_next  = S_REPLY0;
                    status_next = arp_pkg::STATUS_NOT_READY;
                end
            end
            S_REPLY0, S_REPLY1:
            begin
                if (cls.is_o)
                begin
                    state_next  = S_OK_K;
                    status_next = arp_pkg::STATUS_NOT_READY;
                end
                else if (cls.is_e)
                begin
                    state_next  = S_ERR_R1;
                    status_next = arp_pkg::STATUS_NOT_READY;
                end
                else if (cls.is_plus && state_reg == S_REPLY0)
                begin
                    state_next  = S_PLUS_TXT;
                    status_next = arp_pkg::STATUS_NOT_READY;
                end
            end
            S_OK_K:
            begin
                if (cls.is_k)
                begin
                    state_next  = S_END_CR;
                    status_next = arp_pkg::STATUS_NOT_READY;
                end
            end
            S_END_CR, S_ERR_CR:
            begin
                if (cls.is_cr)
                begin
                    state_next  = S_END_LF;
                    status_next = arp_pkg::STATUS_NOT_READY;
                end
            end
            S_END_LF:
            begin
                if (cls.is_lf)
                begin
                    state_next  = S_DONE;
                    status_next = arp_pkg::STATUS_OK;
                end
            end
            S_DONE:
            begin
                status_next = arp_pkg::STATUS_OK;
            end
            S_ERR_R1, S_ERR_R2, S_ERR_R3:
            begin
                if (cls.is_r)
                begin
                    state_next  = (state_reg == S_ERR_R1) ? S_ERR_R2 :
                                  (state_reg == S_ERR_R2) ? S_ERR_O : S_ERR_CR;
                    status_next = arp_pkg::STATUS_NOT_READY;
                end
            end
            S_ERR_O:
            begin
                if (cls.is_o)
                begin
                    state_next  = S_ERR_R3;
                    status_next = arp_pkg::STATUS_NOT_READY;
                end
            end
            S_PLUS_TXT:
            begin
                if (cls.is_print)
                begin
                    status_next = arp_pkg::STATUS_NOT_READY;
                    if (col_reg < arp_pkg::COL_CAP) col_next = col_reg + 8'd1;
                end
                else if (cls.is_cr)
                begin
                    status_next = arp_pkg::STATUS_NOT_READY;
                    col_next    = 8'd0;
                    state_next  = S_PLUS_LF;
                end
            end
            S_PLUS_LF:
            begin
                if (cls.is_lf)
                begin
                    state_next  = S_PLUS_NXT;
                    status_next = arp_pkg::STATUS_NOT_READY;
                end
            end
            S_PLUS_NXT:
            begin
                if (cls.is_cr)
                begin
                    state_next  = S_TAIL_LF;
                    status_next = arp_pkg::STATUS_NOT_READY;
                end
                else if (cls.is_plus)
                begin
                    state_next  = S_PLUS_TXT;
                    status_next = arp_pkg::STATUS_NOT_READY;
                    if (line_reg < arp_pkg::LINE_CAP) line_next = line_reg + 8'd1;
                end
            end
            S_TAIL_LF:
            begin
                if (cls.is_lf)
                begin
                    state_next  = S_REPLY1;
                    status_next = arp_pkg::STATUS_NOT_READY;
                end
            end
            default:
            begin
                status_next = arp_pkg::STATUS_ERR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_WAIT_CR;
            line_reg      <= 8'd0;
            col_reg       <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                state_reg <= state_next;
                line_reg  <= line_next;
                col_reg   <= col_next;
            end
            if (pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            status_reg <= status_next;
        end
    end

endmodule

@@ hw/rtl/at_response_parser_unit.sv @@
// Top level of the AT response parser: classifier, queue and engine.
// Depends on arp_pkg, arp_classifier, arp_queue, arp_engine.
//
// Recognizes modem AT responses one received byte per word: CR LF, then
// OK / ERROR, or one or more '+' lines of printable text each closed by
// CR LF, then CR LF and OK / ERROR. Every input word gives exactly one
// output word carrying a status (0 not ready, 1 ready ok, 2 malformed
// byte, in which case nothing changes), the current '+' line index and the
// column count of the current line; both counters saturate at 255. After
// the closing LF the block answers "ready ok" to every byte until reset,
// whether the reply was OK or ERROR. Throughput is one byte per clock,
// sustained while out_ready is high: the classifier decodes in_valid
// words straight into a two-entry queue, and the engine pops one class
// word per cycle whenever its output register is empty or being taken.
// A word accepted into the queue is popped into the output register,
// raising out_valid, once that register is empty or being taken.
// in_ready drops only when the queue is full, i.e. after output stalls.
module at_response_parser_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] status,
    output logic [7:0] line_index,
    output logic [7:0] column
);

    arp_pkg::arp_class_t in_cls;
    arp_pkg::arp_class_t q_cls;
    arp_pkg::arp_qctl_t  qctl;
    logic                q_valid;
    logic                push;

    assign push = in_valid && in_ready;

    // Front: byte -> class word
    arp_classifier u_classifier (
        .rx_byte (rx_byte),
        .cls     (in_cls)
    );

    // Decoupling queue
    arp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (in_cls),
        .not_full  (in_ready),
        .pop       (qctl.pop),
        .not_empty (q_valid),
        .pop_data  (q_cls)
    );

    // Back: recognizer and output register
    arp_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .cls        (q_cls),
        .qctl       (qctl),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .line_index (line_index),
        .column     (column)
    );

    // Line index only moves when the engine consumes a word
    a_line_moves_on_pop: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) && (line_index != $past(line_index)) |-> $past(qctl.pop))
        else $error("line_index changed without a queue pop");

    // Line index never goes backwards outside reset
    a_line_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> (line_index >= $past(line_index)))
        else $error("line_index decreased");

    // Output drains when taken and nothing is queued
    a_out_drains: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !qctl.valid |=> !out_valid)
        else $error("output word repeated");

    // Pop happens exactly when queue holds data and output can advance
    a_pop_rule: assert property (@(posedge clk) disable iff (!rst_n)
        qctl.pop == (qctl.valid && (!out_valid || out_ready)))
        else $error("queue pop rule violated");

endmodule
